### design/line_raster_color_interp_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the line rasterizer controller
// ---------------------------------------------------------------------------
`ifndef LINE_RASTER_COLOR_INTERP_MACROS_SVH
`define LINE_RASTER_COLOR_INTERP_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define LRCI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define LRCI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/lrci_pkg.sv
// ---------------------------------------------------------------------------
// lrci_pkg
// Shared constants, opcodes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package lrci_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned CHAN_BITS      = 8;
  localparam int unsigned NUM_CHAN       = 4;
  localparam int unsigned COLOR_BITS     = CHAN_BITS * NUM_CHAN;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Commands from the controller to the datapath, at most one per cycle.
  typedef struct packed {
    logic load;      // capture endpoints and colors, seed the dividers
    logic div_step;  // one restoring-division step in every color lane
    logic fin;       // turn quotient/remainder into floor step terms
    logic pix_step;  // register the current pixel and advance the walk
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic line_empty;  // pixel count is zero
    logic last;        // current pixel is the final one
  } dp_status_t;

endpackage

### design/lrci_datapath.sv
// ---------------------------------------------------------------------------
// lrci_datapath
// Line walk registers, per-channel divider lanes, color accumulators and
// the output pixel register.
// ---------------------------------------------------------------------------
module lrci_datapath #(
  parameter int unsigned COORD_BITS = lrci_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lrci_pkg::ctrl_cmd_t             cmd_i,
  output lrci_pkg::dp_status_t            status_o,
  input  logic [COORD_BITS-1:0]           x_start_i,
  input  logic [COORD_BITS-1:0]           y_start_i,
  input  logic [COORD_BITS-1:0]           x_end_i,
  input  logic [COORD_BITS-1:0]           y_end_i,
  input  logic [lrci_pkg::COLOR_BITS-1:0] color_start_i,
  input  logic [lrci_pkg::COLOR_BITS-1:0] color_end_i,
  output logic [COORD_BITS-1:0]           pixel_x_o,
  output logic [COORD_BITS-1:0]           pixel_y_o,
  output logic [lrci_pkg::COLOR_BITS-1:0] pixel_color_o,
  output logic                            last_pixel_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned CW = lrci_pkg::CHAN_BITS;
  localparam int unsigned NC = lrci_pkg::NUM_CHAN;

  function automatic logic [CB-1:0] move_coord(input logic [CB-1:0] c, input logic neg);
    return neg ? c - CB'(1) : c + CB'(1);
  endfunction

  // Walk state
  logic [CB-1:0]        cur_x_q, cur_y_q, n_q, minor_q, idx_q;
  logic signed [CB+1:0] err_q;
  logic                 x_neg_q, y_neg_q, steep_q;

  // Color lanes
  logic [CW-1:0] base_q [NC];
  logic          dneg_q [NC];
  logic [CW-1:0] dvd_q  [NC];
  logic [CB-1:0] rem_q  [NC];
  logic [CW-1:0] qd_q   [NC];
  logic [CB-1:0] rd_q   [NC];
  logic [CW-1:0] qacc_q [NC];
  logic [CB-1:0] racc_q [NC];

  // Output register
  logic [CB-1:0] pix_x_q, pix_y_q;
  logic [lrci_pkg::COLOR_BITS-1:0] pix_color_q, pix_color_d;
  logic          last_q;

  // Load-time deltas
  logic [CB:0]   dx, dy, ndx, ndy;
  logic [CB-1:0] adx, ady;
  logic          steep_d;
  logic [CW:0]   cdiff [NC];
  logic [CW:0]   ncdiff [NC];

  // Divider and step terms
  logic [CB:0]   trial [NC];
  logic [CB:0]   trial_sub [NC];
  logic          fits [NC];
  logic [CB:0]   rsum [NC];
  logic [CB:0]   rsub [NC];
  logic          wrap [NC];

  logic signed [CB+1:0] err_add, err_next;
  logic                 minor_adv, last_d;
  logic [CB-1:0]        next_x, next_y;

  always_comb begin
    dx      = {1'b0, x_end_i} - {1'b0, x_start_i};
    dy      = {1'b0, y_end_i} - {1'b0, y_start_i};
    ndx     = (CB+1)'(0) - dx;
    ndy     = (CB+1)'(0) - dy;
    adx     = dx[CB] ? ndx[CB-1:0] : dx[CB-1:0];
    ady     = dy[CB] ? ndy[CB-1:0] : dy[CB-1:0];
    steep_d = ady > adx;

    for (int k = 0; k < NC; k++) begin
      cdiff[k]  = {1'b0, color_end_i[k*CW +: CW]} - {1'b0, color_start_i[k*CW +: CW]};
      ncdiff[k] = (CW+1)'(0) - cdiff[k];

      trial[k]     = {rem_q[k], dvd_q[k][CW-1]};
      trial_sub[k] = trial[k] - {1'b0, n_q};
      fits[k]      = trial[k] >= {1'b0, n_q};

      rsum[k] = {1'b0, racc_q[k]} + {1'b0, rd_q[k]};
      rsub[k] = rsum[k] - {1'b0, n_q};
      wrap[k] = rsum[k] >= {1'b0, n_q};

      pix_color_d[k*CW +: CW] = base_q[k] + qacc_q[k];
    end

    // Error test: advance the minor axis when twice the error exceeds n.
    err_add   = err_q + $signed({2'b00, minor_q});
    minor_adv = $signed({err_add, 1'b0}) > $signed({3'b000, n_q});
    err_next  = minor_adv ? err_add - $signed({2'b00, n_q}) : err_add;

    next_x = cur_x_q;
    next_y = cur_y_q;
    if (steep_q) begin
      next_y = move_coord(cur_y_q, y_neg_q);
      if (minor_adv) next_x = move_coord(cur_x_q, x_neg_q);
    end else begin
      next_x = move_coord(cur_x_q, x_neg_q);
      if (minor_adv) next_y = move_coord(cur_y_q, y_neg_q);
    end

    last_d = idx_q == (n_q - CB'(1));
  end

  assign status_o.line_empty = n_q == '0;
  assign status_o.last       = last_d;

  // Walk, lane and output registers; clear everything on reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      n_q         <= '0;
      minor_q     <= '0;
      idx_q       <= '0;
      err_q       <= '0;
      x_neg_q     <= 1'b0;
      y_neg_q     <= 1'b0;
      steep_q     <= 1'b0;
      pix_x_q     <= '0;
      pix_y_q     <= '0;
      pix_color_q <= '0;
      last_q      <= 1'b0;
      for (int k = 0; k < NC; k++) begin
        base_q[k] <= '0;
        dneg_q[k] <= 1'b0;
        dvd_q[k]  <= '0;
        rem_q[k]  <= '0;
        qd_q[k]   <= '0;
        rd_q[k]   <= '0;
        qacc_q[k] <= '0;
        racc_q[k] <= '0;
      end
    end else begin
      if (cmd_i.load) begin
        cur_x_q <= x_start_i;
        cur_y_q <= y_start_i;
        x_neg_q <= dx[CB];
        y_neg_q <= dy[CB];
        steep_q <= steep_d;
        n_q     <= steep_d ? ady : adx;
        minor_q <= steep_d ? adx : ady;
        for (int k = 0; k < NC; k++) begin
          base_q[k] <= color_start_i[k*CW +: CW];
          dneg_q[k] <= cdiff[k][CW];
          dvd_q[k]  <= cdiff[k][CW] ? ncdiff[k][CW-1:0] : cdiff[k][CW-1:0];
          rem_q[k]  <= '0;
        end
      end

      if (cmd_i.div_step) begin
        for (int k = 0; k < NC; k++) begin
          rem_q[k] <= fits[k] ? trial_sub[k][CB-1:0] : trial[k][CB-1:0];
          dvd_q[k] <= {dvd_q[k][CW-2:0], fits[k]};
        end
      end

      // Floor division of a negative delta: borrow one when a remainder is left.
      if (cmd_i.fin) begin
        idx_q <= '0;
        err_q <= '0;
        for (int k = 0; k < NC; k++) begin
          qacc_q[k] <= '0;
          racc_q[k] <= '0;
          if (dneg_q[k] && (rem_q[k] != '0)) begin
            qd_q[k] <= ~dvd_q[k];
            rd_q[k] <= n_q - rem_q[k];
          end else if (dneg_q[k]) begin
            qd_q[k] <= CW'(0) - dvd_q[k];
            rd_q[k] <= '0;
          end else begin
            qd_q[k] <= dvd_q[k];
            rd_q[k] <= rem_q[k];
          end
        end
      end

      if (cmd_i.pix_step) begin
        pix_x_q     <= cur_x_q;
        pix_y_q     <= cur_y_q;
        pix_color_q <= pix_color_d;
        last_q      <= last_d;
        cur_x_q     <= next_x;
        cur_y_q     <= next_y;
        err_q       <= err_next;
        idx_q       <= idx_q + CB'(1);
        for (int k = 0; k < NC; k++) begin
          qacc_q[k] <= qacc_q[k] + qd_q[k] + {{(CW-1){1'b0}}, wrap[k]};
          racc_q[k] <= wrap[k] ? rsub[k][CB-1:0] : rsum[k][CB-1:0];
        end
      end
    end
  end

  assign pixel_x_o     = pix_x_q;
  assign pixel_y_o     = pix_y_q;
  assign pixel_color_o = pix_color_q;
  assign last_pixel_o  = last_q;

endmodule

### design/lrci_ctrl.sv
// ---------------------------------------------------------------------------
// lrci_ctrl
// Handshake and sequencing: load, color division, finish, pixel steps.
// ---------------------------------------------------------------------------
`include "line_raster_color_interp_macros.svh"

module lrci_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_op_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  lrci_pkg::dp_status_t status_i,
  output lrci_pkg::ctrl_cmd_t  cmd_o
);

  localparam int unsigned CNT_BITS = $clog2(lrci_pkg::CHAN_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e              state_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic                active_q;
  logic                out_valid_q;
  logic                accept;

  always_comb begin
    in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
    accept     = in_valid_i && in_ready_o;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_op_i == lrci_pkg::OP_LOAD) cmd_o.load = 1'b1;
          else if (active_q) cmd_o.pix_step = 1'b1;
        end
      end
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_FIN:  cmd_o.fin = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // Raise valid on a new pixel; otherwise drop it once taken.
      if (cmd_o.pix_step) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.load) begin
            state_q  <= ST_DIV;
            cnt_q    <= '0;
            active_q <= 1'b0;
          end else if (cmd_o.pix_step && status_i.last) begin
            active_q <= 1'b0;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + CNT_BITS'(1);
          if (cnt_q == CNT_BITS'(lrci_pkg::CHAN_BITS - 1)) state_q <= ST_FIN;
        end
        ST_FIN: begin
          active_q <= !status_i.line_empty;
          state_q  <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  `LRCI_ASSERT(a_cmd_onehot, $onehot0(cmd_o), "more than one datapath command at once")
  `LRCI_ASSERT(a_step_active, !cmd_o.pix_step || active_q, "pixel step without an active line")
  `LRCI_ASSERT_NEXT(a_load_div, cmd_o.load, state_q == ST_DIV && !active_q, "load did not start division")
  `LRCI_ASSERT_NEXT(a_fin_active, cmd_o.fin && !status_i.line_empty, active_q, "nonempty line not activated")

endmodule

### design/line_raster_color_interp.sv
// A step transfer's pixel is written to the output register and shows in the next cycle.
// Throughput: one step per cycle while the output is taken; a load runs through
// accept, 8 restoring-division steps in the color lanes and finish.
// The 8-step divider that splits each color delta by the pixel count sets the load time.
// Reset: asynchronous, active low; clears the controller and datapath registers,
// no line active, no pixel pending.
// ---------------------------------------------------------------------------
// line_raster_color_interp
// Integer line walker with per-pixel color interpolation.
// ---------------------------------------------------------------------------
module line_raster_color_interp #(
  parameter int unsigned COORD_BITS = lrci_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input channel: op 0 loads a line, op 1 requests the next pixel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            op_i,
  input  logic [COORD_BITS-1:0]           x_start_i,
  input  logic [COORD_BITS-1:0]           y_start_i,
  input  logic [COORD_BITS-1:0]           x_end_i,
  input  logic [COORD_BITS-1:0]           y_end_i,
  input  logic [lrci_pkg::COLOR_BITS-1:0] color_start_i,
  input  logic [lrci_pkg::COLOR_BITS-1:0] color_end_i,
  // Output channel: one pixel per step transfer while a line is active
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [COORD_BITS-1:0]           pixel_x_o,
  output logic [COORD_BITS-1:0]           pixel_y_o,
  output logic [lrci_pkg::COLOR_BITS-1:0] pixel_color_o,
  output logic                            last_pixel_o
);

  // The major axis is the one with the larger absolute delta (ties go to x);
  // the line has |major delta| pixels, so the end point is not drawn.
  // Each color byte is a + floor((b - a) * i / n); the floor quotient and
  // remainder of (b - a) / n are found once per load, and then each pixel
  // adds them into a running quotient/remainder pair with one wrap compare.
  // A step with no active line is taken and dropped.

  lrci_pkg::ctrl_cmd_t  cmd;
  lrci_pkg::dp_status_t status;

  lrci_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (op_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath takes load fields only on a load command; the output
  // register is written only on a pixel step, so it holds while stalled.
  lrci_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .x_start_i     (x_start_i),
    .y_start_i     (y_start_i),
    .x_end_i       (x_end_i),
    .y_end_i       (y_end_i),
    .color_start_i (color_start_i),
    .color_end_i   (color_end_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule
